// ----- rtl/rld16_pkg.sv -----
// shared types, command codes and pixel helpers for the line-reference rle decoder
package rld16_pkg;

    // field widths
    localparam int IMG_W_W  = 11;
    localparam int IMG_H_W  = 12;
    localparam int CFG_W    = 12;
    localparam int GRP_N    = 16;
    localparam int PIX_W    = 16;
    localparam int RUN_W    = 10;

    // reset values of the image size registers
    localparam logic [IMG_W_W-1:0] WIDTH_RST  = 11'd640;
    localparam logic [IMG_H_W-1:0] HEIGHT_RST = 12'd480;

    // register indexes
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // stream command bytes
    localparam logic [7:0] CMD_LIT_MAX = 8'hF7;
    localparam logic [7:0] CMD_COPY_1  = 8'hFF;
    localparam logic [7:0] CMD_COPY_2  = 8'hFE;
    localparam logic [7:0] CMD_REP     = 8'hFD;
    localparam logic [7:0] CMD_PAIR    = 8'hFC;
    localparam logic [7:0] CMD_UPLEFT  = 8'hFB;
    localparam logic [7:0] CMD_UPRIGHT = 8'hFA;
    localparam logic [7:0] CMD_SPLIT   = 8'hF9;
    localparam logic [7:0] CMD_ESC     = 8'hF8;

    typedef enum logic [3:0] {
        ST_CMD,
        ST_LIT_HI,
        ST_ESC_LO,
        ST_COUNT,
        ST_P_LO,
        ST_P_HI,
        ST_Q_LO,
        ST_Q_HI,
        ST_F9_HI,
        ST_F9_LO,
        ST_RD,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        SRC_CONST,
        SRC_ALT,
        SRC_MEM
    } src_t;

    // controller to datapath
    typedef struct packed {
        logic ld_held;
        logic ld_code;
        logic ld_run_len;
        logic ld_high;
        logic ld_first;
        logic start_lit;
        logic start_fb;
        logic start_fa;
        logic start_copy;
        logic start_rep;
        logic start_pair;
        logic start_f9;
        logic rd;
        logic emit;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [7:0] code;
        logic       col_full;
        logic       final_pix;
        logic       out_free;
        logic       src_mem;
        logic       f9_more;
    } dp_stat_t;

    // high part of a split pixel
    function automatic logic [15:0] split_high(input logic [7:0] b);
        split_high = {b[7:5], 2'b00, b[4:3], 4'b0000, b[2:0], 2'b00};
    endfunction

    // low part of a split pixel
    function automatic logic [15:0] split_low(input logic [7:0] b);
        split_low = {3'b000, b[7:6], 2'b00, b[5:2], 3'b000, b[1:0]};
    endfunction

    // slot of the row k rows above the current one
    function automatic logic [1:0] slot_back(input logic [1:0] slot, input logic [1:0] k);
        logic [2:0] s;
        s = {1'b0, slot} + 3'd3 - {1'b0, k};
        if (s >= 3'd3)
        begin
            s = s - 3'd3;
        end
        slot_back = s[1:0];
    endfunction

endpackage

// ----- rtl/rld16_ram.sv -----
// generic single-port-write ram with registered read
module rld16_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 3072
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/rld16_ctrl.sv -----
// byte parser and run sequencer for the line-reference rle decoder
module rld16_ctrl import rld16_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  dp_stat_t   stat,
    output ctl_cmd_t   cmd
);

    state_t state_reg, state_next;
    logic   f9_mode_reg, f9_mode_next;
    logic   parse_st;
    logic   acc;
    logic   is_copy;
    logic   run_done;

    // parse states take bytes
    always_comb
    begin
        unique case (state_reg)
            ST_RD, ST_RUN: parse_st = 1'b0;
            default:       parse_st = 1'b1;
        endcase
    end

    assign in_ready = parse_st;
    assign acc      = in_valid && parse_st;
    assign is_copy  = (stat.code == CMD_COPY_1) || (stat.code == CMD_COPY_2);
    assign run_done = stat.col_full || (stat.out_free && stat.final_pix);

    // next state
    always_comb
    begin
        state_next   = state_reg;
        f9_mode_next = f9_mode_reg;
        if (cfg_we)
        begin
            state_next   = ST_CMD;
            f9_mode_next = 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_CMD:
                begin
                    if (acc)
                    begin
                        f9_mode_next = 1'b0;
                        if (in_byte <= CMD_LIT_MAX)
                        begin
                            state_next = ST_LIT_HI;
                        end
                        else if (in_byte == CMD_UPLEFT || in_byte == CMD_UPRIGHT)
                        begin
                            state_next = ST_RD;
                        end
                        else if (in_byte == CMD_ESC)
                        begin
                            state_next = ST_ESC_LO;
                        end
                        else
                        begin
                            state_next = ST_COUNT;
                        end
                    end
                end
                ST_LIT_HI:
                begin
                    if (acc)
                    begin
                        state_next   = ST_RUN;
                        f9_mode_next = 1'b0;
                    end
                end
                ST_ESC_LO:
                begin
                    if (acc)
                    begin
                        state_next = ST_LIT_HI;
                    end
                end
                ST_COUNT:
                begin
                    if (acc)
                    begin
                        f9_mode_next = 1'b0;
                        if (is_copy)
                        begin
                            state_next = ST_RD;
                        end
                        else if (stat.code == CMD_REP || stat.code == CMD_PAIR)
                        begin
                            state_next = ST_P_LO;
                        end
                        else
                        begin
                            state_next = ST_F9_HI;
                        end
                    end
                end
                ST_P_LO:
                begin
                    if (acc)
                    begin
                        state_next = ST_P_HI;
                    end
                end
                ST_P_HI:
                begin
                    if (acc)
                    begin
                        state_next = (stat.code == CMD_PAIR) ? ST_Q_LO : ST_RUN;
                    end
                end
                ST_Q_LO:
                begin
                    if (acc)
                    begin
                        state_next = ST_Q_HI;
                    end
                end
                ST_Q_HI:
                begin
                    if (acc)
                    begin
                        state_next = ST_RUN;
                    end
                end
                ST_F9_HI:
                begin
                    if (acc)
                    begin
                        state_next = ST_F9_LO;
                    end
                end
                ST_F9_LO:
                begin
                    if (acc)
                    begin
                        state_next   = ST_RUN;
                        f9_mode_next = 1'b1;
                    end
                end
                ST_RD:
                begin
                    state_next = ST_RUN;
                end
                ST_RUN:
                begin
                    if (run_done)
                    begin
                        state_next = (f9_mode_reg && stat.f9_more) ? ST_F9_LO : ST_CMD;
                    end
                    else if (stat.out_free && stat.src_mem)
                    begin
                        state_next = ST_RD;
                    end
                end
                default:
                begin
                    state_next = ST_CMD;
                end
            endcase
        end
    end

    // datapath commands
    always_comb
    begin
        cmd = '0;
        if (!cfg_we)
        begin
            unique case (state_reg)
                ST_CMD:
                begin
                    if (acc)
                    begin
                        if (in_byte <= CMD_LIT_MAX)
                        begin
                            cmd.ld_held = 1'b1;
                        end
                        else if (in_byte == CMD_UPLEFT)
                        begin
                            cmd.start_fb = 1'b1;
                        end
                        else if (in_byte == CMD_UPRIGHT)
                        begin
                            cmd.start_fa = 1'b1;
                        end
                        else if (in_byte != CMD_ESC)
                        begin
                            cmd.ld_code = 1'b1;
                        end
                    end
                end
                ST_LIT_HI:  cmd.start_lit = acc;
                ST_ESC_LO:  cmd.ld_held   = acc;
                ST_COUNT:
                begin
                    cmd.start_copy = acc && is_copy;
                    cmd.ld_run_len = acc && !is_copy;
                end
                ST_P_LO:    cmd.ld_held = acc;
                ST_P_HI:
                begin
                    cmd.ld_first  = acc && (stat.code == CMD_PAIR);
                    cmd.start_rep = acc && (stat.code != CMD_PAIR);
                end
                ST_Q_LO:    cmd.ld_held    = acc;
                ST_Q_HI:    cmd.start_pair = acc;
                ST_F9_HI:   cmd.ld_high    = acc;
                ST_F9_LO:   cmd.start_f9   = acc;
                ST_RD:      cmd.rd         = 1'b1;
                ST_RUN:
                begin
                    cmd.emit   = !stat.col_full && stat.out_free;
                    cmd.finish = run_done && !(f9_mode_reg && stat.f9_more);
                end
                default:    cmd = '0;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CMD;
            f9_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            f9_mode_reg <= f9_mode_next;
        end
    end

endmodule

// ----- rtl/rld16_dp.sv -----
// datapath: position counters, row store, pixel sources and group packing
module rld16_dp import rld16_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic [7:0]             in_byte,
    input  ctl_cmd_t               cmd,
    output dp_stat_t               stat,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [GRP_N*PIX_W-1:0] out_pix,
    output logic [4:0]             out_count,
    output logic                   out_last,
    output logic                   out_eor,
    output logic                   out_eoi
);

    localparam int COL_W  = $clog2(MAX_ROW_WIDTH + 1);
    localparam int DEPTH  = 3 * MAX_ROW_WIDTH;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CMP_W  = (COL_W > IMG_W_W) ? COL_W : IMG_W_W;

    logic [IMG_W_W-1:0] width_reg, width_next;
    logic [IMG_H_W-1:0] height_reg, height_next;
    logic [COL_W-1:0]   column_reg, column_next;
    logic [IMG_H_W-1:0] row_reg, row_next;
    logic [1:0]         slot_reg, slot_next;
    logic [7:0]         held_reg, held_next;
    logic [7:0]         code_reg, code_next;
    logic [RUN_W-1:0]   run_len_reg, run_len_next;
    logic [PIX_W-1:0]   high_reg, high_next;
    logic [PIX_W-1:0]   first_reg, first_next;
    logic [PIX_W-1:0]   second_reg, second_next;
    logic [RUN_W-1:0]   rem_reg, rem_next;
    src_t               src_reg, src_next;
    logic               alt_reg, alt_next;
    logic [1:0]         rd_slot_reg, rd_slot_next;
    logic [COL_W-1:0]   rd_col_reg, rd_col_next;
    logic               rd_fixed_reg, rd_fixed_next;
    logic               rd_zero_reg, rd_zero_next;
    logic [PIX_W-1:0]   grp_reg [GRP_N];
    logic [PIX_W-1:0]   grp_next [GRP_N];
    logic [3:0]         grp_cnt_reg, grp_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [GRP_N*PIX_W-1:0] out_pix_reg, out_pix_next;
    logic [4:0]         out_count_reg, out_count_next;
    logic               out_last_reg, out_last_next;
    logic               out_eor_reg, out_eor_next;
    logic               out_eoi_reg, out_eoi_next;

    logic [CMP_W-1:0]   w_ext;
    logic [COL_W-1:0]   eff_w;
    logic [IMG_H_W-1:0] eff_h;
    logic [COL_W:0]     col_inc;
    logic               col_full;
    logic               at_row_end;
    logic               last_row;
    logic               final_pix;
    logic               out_free;
    logic               close_grp;
    logic [PIX_W-1:0]   new_pix;
    logic [PIX_W-1:0]   byte_pix;
    logic [PIX_W-1:0]   ram_q;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [COL_W-1:0]   rd_col_sel;
    logic [1:0]         copy_k;

    // base address of a row slot
    function automatic logic [ADDR_W-1:0] slot_base(input logic [1:0] s);
        logic [ADDR_W-1:0] b;
        unique case (s)
            2'd0:    b = '0;
            2'd1:    b = ADDR_W'(MAX_ROW_WIDTH);
            default: b = ADDR_W'(2 * MAX_ROW_WIDTH);
        endcase
        slot_base = b;
    endfunction

    // effective image size
    always_comb
    begin
        w_ext = CMP_W'(width_reg);
        if (w_ext == '0)
        begin
            eff_w = COL_W'(1);
        end
        else if (w_ext > CMP_W'(MAX_ROW_WIDTH))
        begin
            eff_w = COL_W'(MAX_ROW_WIDTH);
        end
        else
        begin
            eff_w = COL_W'(w_ext);
        end
        eff_h = (height_reg == '0) ? IMG_H_W'(1) : height_reg;
    end

    // position status
    assign col_inc    = {1'b0, column_reg} + 1'b1;
    assign col_full   = column_reg >= eff_w;
    assign at_row_end = col_inc == {1'b0, eff_w};
    assign last_row   = ({1'b0, row_reg} + 1'b1) >= {1'b0, eff_h};
    assign final_pix  = (rem_reg == RUN_W'(1)) || at_row_end;
    assign out_free   = !out_valid_reg || out_ready;
    assign close_grp  = final_pix || (grp_cnt_reg == 4'd15);
    assign byte_pix   = {in_byte, held_reg};
    assign copy_k     = (code_reg == CMD_COPY_1) ? 2'd1 : 2'd2;

    // pixel source select
    always_comb
    begin
        unique case (src_reg)
            SRC_CONST: new_pix = first_reg;
            SRC_ALT:   new_pix = alt_reg ? second_reg : first_reg;
            SRC_MEM:   new_pix = rd_zero_reg ? '0 : ram_q;
            default:   new_pix = first_reg;
        endcase
    end

    // row store addresses
    assign rd_col_sel = rd_fixed_reg ? rd_col_reg : column_reg;
    assign raddr = slot_base(rd_slot_reg) + ADDR_W'(rd_col_sel);
    assign waddr = slot_base(slot_reg) + ADDR_W'(column_reg);

    rld16_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_row_ram (
        .clk   (clk),
        .we    (cmd.emit),
        .waddr (waddr),
        .wdata (new_pix),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // parser registers and run setup
    always_comb
    begin
        width_next    = width_reg;
        height_next   = height_reg;
        held_next     = held_reg;
        code_next     = code_reg;
        run_len_next  = run_len_reg;
        high_next     = high_reg;
        first_next    = first_reg;
        second_next   = second_reg;
        rem_next      = rem_reg;
        src_next      = src_reg;
        alt_next      = alt_reg;
        rd_slot_next  = rd_slot_reg;
        rd_col_next   = rd_col_reg;
        rd_fixed_next = rd_fixed_reg;
        rd_zero_next  = rd_zero_reg;

        if (cmd.ld_held)
        begin
            held_next = in_byte;
        end
        if (cmd.ld_code)
        begin
            code_next = in_byte;
        end
        if (cmd.ld_run_len)
        begin
            if (code_reg == CMD_REP)
            begin
                run_len_next = RUN_W'(in_byte) + RUN_W'(3);
            end
            else if (code_reg == CMD_PAIR)
            begin
                run_len_next = {RUN_W'(in_byte) + RUN_W'(2)} << 1;
            end
            else
            begin
                run_len_next = RUN_W'(in_byte) + RUN_W'(1);
            end
        end
        if (cmd.ld_high)
        begin
            high_next = split_high(in_byte);
        end
        if (cmd.ld_first)
        begin
            first_next = byte_pix;
        end
        if (cmd.start_lit)
        begin
            first_next = byte_pix;
            rem_next   = RUN_W'(1);
            src_next   = SRC_CONST;
        end
        if (cmd.start_rep)
        begin
            first_next = byte_pix;
            rem_next   = run_len_reg;
            src_next   = SRC_CONST;
        end
        if (cmd.start_pair)
        begin
            second_next = byte_pix;
            rem_next    = run_len_reg;
            src_next    = SRC_ALT;
            alt_next    = 1'b0;
        end
        if (cmd.start_f9)
        begin
            first_next   = high_reg | split_low(in_byte);
            rem_next     = RUN_W'(1);
            src_next     = SRC_CONST;
            run_len_next = run_len_reg - RUN_W'(1);
        end
        if (cmd.start_copy)
        begin
            rem_next      = RUN_W'(in_byte) + RUN_W'(2);
            src_next      = SRC_MEM;
            rd_fixed_next = 1'b0;
            rd_slot_next  = slot_back(slot_reg, copy_k);
            rd_zero_next  = row_reg < IMG_H_W'(copy_k);
        end
        // up-left diagonal, wrapping to the end of two rows up at column zero
        if (cmd.start_fb)
        begin
            rem_next      = RUN_W'(1);
            src_next      = SRC_MEM;
            rd_fixed_next = 1'b1;
            if (column_reg == '0)
            begin
                rd_col_next  = eff_w - 1'b1;
                rd_slot_next = slot_back(slot_reg, 2'd2);
                rd_zero_next = row_reg < IMG_H_W'(2);
            end
            else
            begin
                rd_col_next  = column_reg - 1'b1;
                rd_slot_next = slot_back(slot_reg, 2'd1);
                rd_zero_next = row_reg < IMG_H_W'(1);
            end
        end
        // up-right diagonal, wrapping to column zero of this row at the last column
        if (cmd.start_fa)
        begin
            rem_next      = RUN_W'(1);
            src_next      = SRC_MEM;
            rd_fixed_next = 1'b1;
            if (at_row_end)
            begin
                rd_col_next  = '0;
                rd_slot_next = slot_reg;
                rd_zero_next = column_reg == '0;
            end
            else
            begin
                rd_col_next  = col_inc[COL_W-1:0];
                rd_slot_next = slot_back(slot_reg, 2'd1);
                rd_zero_next = row_reg < IMG_H_W'(1);
            end
        end
        if (cmd.emit)
        begin
            rem_next = rem_reg - RUN_W'(1);
            alt_next = !alt_reg;
        end
        // register writes restart the image
        if (cfg_we)
        begin
            if (cfg_addr == REG_WIDTH)
            begin
                width_next = cfg_wdata[IMG_W_W-1:0];
            end
            else
            begin
                height_next = cfg_wdata[IMG_H_W-1:0];
            end
            held_next    = '0;
            code_next    = '0;
            run_len_next = '0;
            high_next    = '0;
            first_next   = '0;
        end
    end

    // position update, the row also closes when the finishing pixel fills it
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        slot_next   = slot_reg;
        if (cmd.emit)
        begin
            column_next = col_inc[COL_W-1:0];
        end
        if (cmd.finish && (col_full || (cmd.emit && at_row_end)))
        begin
            column_next = '0;
            if (last_row)
            begin
                row_next  = '0;
                slot_next = '0;
            end
            else
            begin
                row_next  = row_reg + 1'b1;
                slot_next = (slot_reg == 2'd2) ? 2'd0 : slot_reg + 1'b1;
            end
        end
        if (cfg_we)
        begin
            column_next = '0;
            row_next    = '0;
            slot_next   = '0;
        end
    end

    // group collection and output register
    always_comb
    begin
        grp_next       = grp_reg;
        grp_cnt_next   = grp_cnt_reg;
        out_pix_next   = out_pix_reg;
        out_count_next = out_count_reg;
        out_last_next  = out_last_reg;
        out_eor_next   = out_eor_reg;
        out_eoi_next   = out_eoi_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.emit)
        begin
            if (close_grp)
            begin
                for (int i = 0; i < GRP_N; i++)
                begin
                    if (4'(i) < grp_cnt_reg)
                    begin
                        out_pix_next[i*PIX_W +: PIX_W] = grp_reg[i];
                    end
                    else if (4'(i) == grp_cnt_reg)
                    begin
                        out_pix_next[i*PIX_W +: PIX_W] = new_pix;
                    end
                    else
                    begin
                        out_pix_next[i*PIX_W +: PIX_W] = '0;
                    end
                end
                out_count_next = {1'b0, grp_cnt_reg} + 5'd1;
                out_last_next  = final_pix;
                out_eor_next   = at_row_end;
                out_eoi_next   = at_row_end && last_row;
                out_valid_next = 1'b1;
                grp_cnt_next   = '0;
            end
            else
            begin
                grp_next[grp_cnt_reg] = new_pix;
                grp_cnt_next          = grp_cnt_reg + 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RST;
            height_reg    <= HEIGHT_RST;
            column_reg    <= '0;
            row_reg       <= '0;
            slot_reg      <= '0;
            held_reg      <= '0;
            code_reg      <= '0;
            run_len_reg   <= '0;
            high_reg      <= '0;
            first_reg     <= '0;
            rem_reg       <= '0;
            src_reg       <= SRC_CONST;
            alt_reg       <= 1'b0;
            rd_fixed_reg  <= 1'b0;
            rd_zero_reg   <= 1'b0;
            rd_slot_reg   <= '0;
            grp_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            column_reg    <= column_next;
            row_reg       <= row_next;
            slot_reg      <= slot_next;
            held_reg      <= held_next;
            code_reg      <= code_next;
            run_len_reg   <= run_len_next;
            high_reg      <= high_next;
            first_reg     <= first_next;
            rem_reg       <= rem_next;
            src_reg       <= src_next;
            alt_reg       <= alt_next;
            rd_fixed_reg  <= rd_fixed_next;
            rd_zero_reg   <= rd_zero_next;
            rd_slot_reg   <= rd_slot_next;
            grp_cnt_reg   <= grp_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        second_reg    <= second_next;
        rd_col_reg    <= rd_col_next;
        grp_reg       <= grp_next;
        out_pix_reg   <= out_pix_next;
        out_count_reg <= out_count_next;
        out_last_reg  <= out_last_next;
        out_eor_reg   <= out_eor_next;
        out_eoi_reg   <= out_eoi_next;
    end

    // status to the controller
    always_comb
    begin
        stat.code      = code_reg;
        stat.col_full  = col_full;
        stat.final_pix = final_pix;
        stat.out_free  = out_free;
        stat.src_mem   = src_reg == SRC_MEM;
        stat.f9_more   = run_len_reg != '0;
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;
    assign out_eor   = out_eor_reg;
    assign out_eoi   = out_eoi_reg;

endmodule

// ----- rtl/line_ref_rle_decoder_16bpp.sv -----
// top level of the line-reference rle decoder, 16 bits per pixel
//
// channel   dir  width  contents
// s_axis    in   8      tdata: stream_byte
// m_axis    out  264    tdata: pixels_a, pixels_b, pixels_c, pixels_d, pixel_count;
//                       tlast: last_of_run; tuser: end_of_row, end_of_image
// cfg       in   12     index 0: image_width, index 1: image_height
//
// a parameter byte is taken without waiting; a byte that yields pixels then holds
// the input while the run unit emits them: one pixel per cycle from registers while
// the output is free, each row copy or diagonal pixel after a registered row ram read
// rows live in a three-row ram; every read lands on a column already written
// this image or is forced to zero, so reset needs no ram clearing
// a full output register holds the run unit until the group is taken
module line_ref_rle_decoder_16bpp import rld16_pkg::*; #(
    parameter int MAX_ROW_WIDTH = 1024
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_addr,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // stream_byte
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [263:0]     m_tdata,   // pixels_a, pixels_b, pixels_c, pixels_d, pixel_count
    output logic             m_tlast,
    output logic [1:0]       m_tuser    // end_of_row, end_of_image
);

    ctl_cmd_t               cmd;
    dp_stat_t               stat;
    logic [GRP_N*PIX_W-1:0] out_pix;
    logic [4:0]             out_count;
    logic                   out_eor;
    logic                   out_eoi;

    rld16_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_byte  (s_tdata),
        .stat     (stat),
        .cmd      (cmd)
    );

    rld16_dp #(
        .MAX_ROW_WIDTH (MAX_ROW_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_byte   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix),
        .out_count (out_count),
        .out_last  (m_tlast),
        .out_eor   (out_eor),
        .out_eoi   (out_eoi)
    );

    // output packing
    assign m_tdata = {3'b000, out_count, out_pix};
    assign m_tuser = {out_eoi, out_eor};

endmodule
